/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// name: label, clk/rst_n: clock and active-low reset, prop: property body
`ifndef ASSERT_OFF
`define HRG_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HRG_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define HRG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HRG_ASSERT(name, clk, rst_n, prop, msg)
`define HRG_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define HRG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/hrg_pkg.sv */
package hrg_pkg;

  localparam int KEY_W      = 32;
  localparam int HEAP_DEPTH = 32;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);

  // configuration register
  localparam int CAP_W     = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  typedef enum logic {
    REG_HEAP_CAPACITY = 1'b0
  } reg_idx_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } hrg_stat_t;

endpackage

/* sv/hrg_in_if.sv */
interface hrg_in_if import hrg_pkg::*; ();
  logic valid;
  logic ready;
  logic opcode;
  key_t new_value;

  modport source (output valid, opcode, new_value, input ready);
  modport sink   (input valid, opcode, new_value, output ready);
endinterface

/* sv/hrg_out_if.sv */
interface hrg_out_if import hrg_pkg::*; ();
  logic valid;
  logic ready;
  key_t out_value;
  logic run_marker;
  logic burst_last;

  modport source (output valid, out_value, run_marker, burst_last, input ready);
  modport sink   (input valid, out_value, run_marker, burst_last, output ready);
endinterface

/* sv/heap_run_generator.sv */
// channel | dir | beat
// in_ch   | in  | opcode, new_value
// out_ch  | out | out_value, run_marker, burst_last
// cfg_*   | in  | APB write/read of heap_capacity at byte address 0
//
// A filling push writes straight into an empty heap, else the hole climbs level by level in S_UP.
// A replacement emits the top, then sifts down level by level (S_DN_RD, S_DN_CMP), 5 levels max.
// A drain (from S_IDLE on a flush, through S_TOP on a push) emits each key in S_D_EMIT, sifts
// down, rereads in S_D_RD, then emits the marker; a beat waiting on out_ch.ready stalls it.
// Reset is synchronous, active low; the store itself is not cleared.
// One output register: a new item is taken while the last beat waits on out_ch.ready.
`include "assert_macros.svh"

module heap_run_generator import hrg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  hrg_in_if.sink            in_ch,
  hrg_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [CNT_W-1:0] eff_cap;
  hrg_stat_t        stat;

  hrg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .eff_cap (eff_cap)
  );

  hrg_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .eff_cap (eff_cap),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .stat    (stat)
  );

  `HRG_ASSERT(a_count_bound, clk, rst_n, stat.count <= CNT_W'(HEAP_DEPTH), "heap count past depth")
  `HRG_ASSERT_IMPLY(a_busy_no_in, clk, rst_n, stat.busy, !in_ch.ready, "input taken while busy")
  `HRG_ASSERT_NEXT(a_flush_busy, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.opcode == OP_FLUSH, stat.busy, "flush did not start a drain")
  `HRG_ASSERT_IMPLY(a_marker_zero, clk, rst_n, out_ch.valid && out_ch.run_marker, out_ch.out_value == '0 && out_ch.burst_last, "marker beat malformed")

endmodule

/* sv/hrg_ram.sv */
module hrg_ram #(
  parameter int DEPTH = 32,
  parameter int DW    = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* sv/hrg_cfg.sv */
module hrg_cfg import hrg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  eff_cap
);

  localparam int EW = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  logic [CAP_W-1:0] cap_r;
  logic             sel_cap;

  assign sel_cap = (paddr[2] == REG_HEAP_CAPACITY);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && sel_cap) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_cap) begin
      prdata = CFG_DW'(cap_r);
    end
  end

  // zero acts as one, anything past the store depth as the depth
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (EW'(cap_r) > EW'(HEAP_DEPTH)) begin
      eff_cap = CNT_W'(HEAP_DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

endmodule

/* sv/hrg_core.sv */
module hrg_core import hrg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] eff_cap,
  hrg_in_if.sink           in_ch,
  hrg_out_if.source        out_ch,
  output hrg_stat_t        stat
);

  localparam int CW = IDX_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_UP, S_UP_FIN, S_TOP, S_DN_RD, S_DN_CMP, S_D_RD, S_D_EMIT
  } state_t;

  function automatic logic [IDX_W-1:0] parent_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] d;
    d = i - IDX_W'(1);
    return d >> 1;
  endfunction

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  key_t             key_r, key_nxt;
  key_t             sk_r, sk_nxt;
  logic [CNT_W-1:0] sz_r, sz_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             drain_r, drain_nxt;
  logic             restart_r, restart_nxt;
  logic             rok_r, rok_nxt;
  logic             ovalid_r, ovalid_nxt;
  key_t             ovalue_r, ovalue_nxt;
  logic             omark_r, omark_nxt;
  logic             olast_r, olast_nxt;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
  key_t             wdata;
  logic [KEY_W-1:0] rdata_a_raw, rdata_b_raw;
  key_t             rd_a, rd_b;

  logic             out_free;
  logic             load_out;
  key_t             lo_value;
  logic             lo_mark, lo_last;
  logic [IDX_W-1:0] last_idx, up_par;
  logic [CW-1:0]    l_w, r_w, sz_w;
  logic             pick_r;
  key_t             child;

  hrg_ram #(.DEPTH(HEAP_DEPTH), .DW(KEY_W), .AW(IDX_W)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a_raw),
    .rdata_b (rdata_b_raw)
  );

  assign rd_a     = $signed(rdata_a_raw);
  assign rd_b     = $signed(rdata_b_raw);
  assign out_free = !ovalid_r || out_ch.ready;
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign up_par   = parent_idx(idx_r);
  assign l_w      = {1'b0, idx_r, 1'b1};
  assign r_w      = l_w + CW'(1);
  assign sz_w     = CW'(sz_r);
  // right child wins a tie
  assign pick_r   = rok_r && (rd_b <= rd_a);
  assign child    = pick_r ? rd_b : rd_a;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = ovalid_r;
  assign out_ch.out_value  = ovalue_r;
  assign out_ch.run_marker = omark_r;
  assign out_ch.burst_last = olast_r;
  assign stat.count        = count_r;
  assign stat.busy         = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    key_nxt     = key_r;
    sk_nxt      = sk_r;
    sz_nxt      = sz_r;
    idx_nxt     = idx_r;
    drain_nxt   = drain_r;
    restart_nxt = restart_r;
    rok_nxt     = rok_r;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = sk_r;
    re          = 1'b0;
    raddr_a     = '0;
    raddr_b     = last_idx;
    load_out    = 1'b0;
    lo_value    = '0;
    lo_mark     = 1'b0;
    lo_last     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          key_nxt = in_ch.new_value;
          re      = 1'b1;
          if (in_ch.opcode == OP_FLUSH) begin
            restart_nxt = 1'b0;
            state_nxt   = S_D_EMIT;
          end else if (count_r < eff_cap) begin
            count_nxt = count_r + CNT_W'(1);
            if (count_r == '0) begin
              we    = 1'b1;
              waddr = '0;
              wdata = in_ch.new_value;
            end else begin
              raddr_a   = parent_idx(IDX_W'(count_r));
              idx_nxt   = IDX_W'(count_r);
              state_nxt = S_UP;
            end
          end else begin
            state_nxt = S_TOP;
          end
        end
      end

      // hole moves up while the new key is smaller than the parent
      S_UP: begin
        we = 1'b1;
        if (key_r < rd_a) begin
          wdata   = rd_a;
          idx_nxt = up_par;
          if (up_par == '0) begin
            state_nxt = S_UP_FIN;
          end else begin
            re      = 1'b1;
            raddr_a = parent_idx(up_par);
          end
        end else begin
          wdata     = key_r;
          state_nxt = S_IDLE;
        end
      end

      S_UP_FIN: begin
        we        = 1'b1;
        wdata     = key_r;
        state_nxt = S_IDLE;
      end

      S_TOP: begin
        if (key_r > rd_a) begin
          if (out_free) begin
            load_out  = 1'b1;
            lo_value  = rd_a;
            lo_last   = 1'b1;
            sk_nxt    = key_r;
            sz_nxt    = count_r;
            idx_nxt   = '0;
            drain_nxt = 1'b0;
            state_nxt = S_DN_RD;
          end
        end else begin
          restart_nxt = 1'b1;
          state_nxt   = S_D_EMIT;
        end
      end

      S_DN_RD: begin
        if (l_w < sz_w) begin
          re        = 1'b1;
          raddr_a   = l_w[IDX_W-1:0];
          rok_nxt   = (r_w < sz_w);
          raddr_b   = (r_w < sz_w) ? r_w[IDX_W-1:0] : l_w[IDX_W-1:0];
          state_nxt = S_DN_CMP;
        end else begin
          we        = 1'b1;
          state_nxt = drain_r ? S_D_RD : S_IDLE;
        end
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (child < sk_r) begin
          wdata     = child;
          idx_nxt   = pick_r ? r_w[IDX_W-1:0] : l_w[IDX_W-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = drain_r ? S_D_RD : S_IDLE;
        end
      end

      // separate read cycle: the last sift write may touch the top or tail
      S_D_RD: begin
        re        = 1'b1;
        state_nxt = S_D_EMIT;
      end

      S_D_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (count_r == '0) begin
            lo_mark   = 1'b1;
            lo_last   = 1'b1;
            state_nxt = S_IDLE;
            if (restart_r) begin
              we        = 1'b1;
              waddr     = '0;
              wdata     = key_r;
              count_nxt = CNT_W'(1);
            end
          end else begin
            lo_value  = rd_a;
            count_nxt = count_r - CNT_W'(1);
            sk_nxt    = rd_b;
            sz_nxt    = count_r - CNT_W'(1);
            idx_nxt   = '0;
            drain_nxt = 1'b1;
            state_nxt = S_DN_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (load_out) begin
      ovalid_nxt = 1'b1;
      ovalue_nxt = lo_value;
      omark_nxt  = lo_mark;
      olast_nxt  = lo_last;
    end else begin
      ovalid_nxt = ovalid_r && !out_ch.ready;
      ovalue_nxt = ovalue_r;
      omark_nxt  = omark_r;
      olast_nxt  = olast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      drain_r   <= 1'b0;
      restart_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      drain_r   <= drain_nxt;
      restart_r <= restart_nxt;
      ovalid_r  <= ovalid_nxt;
    end
    key_r    <= key_nxt;
    sk_r     <= sk_nxt;
    sz_r     <= sz_nxt;
    idx_r    <= idx_nxt;
    rok_r    <= rok_nxt;
    ovalue_r <= ovalue_nxt;
    omark_r  <= omark_nxt;
    olast_r  <= olast_nxt;
  end

endmodule

/* tb/sv/tb_heap_run_generator.sv */
module tb_heap_run_generator;
  import hrg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          SETTLE_CYCLES = 32;
  localparam int          HOLD_CYCLES = 400;
  localparam int          PHASES = 8;
  localparam int          PHASE_ITEMS = 60;
  localparam int          PLAN_ROWS = 24;
  localparam key_t        KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t        KEY_MIN = 32'sh8000_0000;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    key_t value;
    logic marker;
    logic last;
  } beat_t;

  // known: the beat is typed in the row (nbeats 0 or 1), else the heap model decides
  typedef struct packed {
    row_kind_t kind;
    op_t       op;
    key_t      value;
    logic      known;
    logic      nbeats;
    key_t      exp_value;
    logic      exp_marker;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  hrg_in_if  in_ch ();
  hrg_out_if out_ch ();

  heap_run_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // heap model state
  key_t             heap_keys [HEAP_DEPTH];
  int unsigned      heap_fill;
  logic [CAP_W-1:0] cap_reg;
  beat_t            select_beats [$];
  beat_t            run_beats_owed [$];
  beat_t            head_beat;

  // what the sender says about the beat on offer; moves with the payload
  logic             row_known;
  logic             row_nbeats;
  key_t             row_value;
  logic             row_marker;

  int unsigned      cycles;
  int               mismatches;
  int               hold_len;
  logic             tx_calm;
  logic             rx_calm;
  row_t             plan [PLAN_ROWS];

  function automatic int unsigned cap_in_use();
    if (cap_reg == '0) return 1;
    if (cap_reg > HEAP_DEPTH) return HEAP_DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic void sink_top(input int unsigned size);
    int unsigned i;
    int unsigned c;
    key_t t;
    i = 0;
    while (2 * i + 1 < size) begin
      c = 2 * i + 1;
      // tie goes to the right child
      if (c + 1 < size && heap_keys[c + 1] <= heap_keys[c]) c = c + 1;
      if (heap_keys[c] < heap_keys[i]) begin
        t = heap_keys[i];
        heap_keys[i] = heap_keys[c];
        heap_keys[c] = t;
        i = c;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void float_up(input key_t key);
    int unsigned i;
    int unsigned p;
    key_t t;
    i = heap_fill;
    heap_keys[i] = key;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_keys[i] < heap_keys[p]) begin
        t = heap_keys[i];
        heap_keys[i] = heap_keys[p];
        heap_keys[p] = t;
        i = p;
      end else begin
        break;
      end
    end
    heap_fill++;
  endfunction

  function automatic void drain_run();
    while (heap_fill > 0) begin
      select_beats.push_back('{heap_keys[0], 1'b0, 1'b0});
      heap_fill--;
      heap_keys[0] = heap_keys[heap_fill];
      sink_top(heap_fill);
    end
    select_beats.push_back('{32'sd0, 1'b1, 1'b0});
  endfunction

  function automatic void select_step(input op_t op, input key_t key);
    select_beats.delete();
    if (op == OP_FLUSH) begin
      drain_run();
    end else if (heap_fill < cap_in_use()) begin
      float_up(key);
      return;
    end else if (key > heap_keys[0]) begin
      select_beats.push_back('{heap_keys[0], 1'b0, 1'b0});
      heap_keys[0] = key;
      sink_top(heap_fill);
    end else begin
      drain_run();
      heap_keys[0] = key;
      heap_fill = 1;
    end
    select_beats[select_beats.size() - 1].last = 1'b1;
  endfunction

  // input acceptance first, so a beat can never overtake its own prediction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      select_step(op_t'(in_ch.opcode), in_ch.new_value);
      if (row_known) begin
        if (row_nbeats) run_beats_owed.push_back('{row_value, row_marker, 1'b1});
      end else begin
        foreach (select_beats[i]) run_beats_owed.push_back(select_beats[i]);
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (run_beats_owed.size() == 0) begin
        $display("%0t: beat with nothing owed: value %0d marker %0b last %0b", $time,
                 out_ch.out_value, out_ch.run_marker, out_ch.burst_last);
        mismatches++;
      end else begin
        head_beat = run_beats_owed.pop_front();
        if (out_ch.out_value !== head_beat.value) begin
          $display("%0t: out_value expected %0d got %0d", $time, head_beat.value,
                   out_ch.out_value);
          mismatches++;
        end
        if (out_ch.run_marker !== head_beat.marker) begin
          $display("%0t: run_marker expected %0b got %0b", $time, head_beat.marker,
                   out_ch.run_marker);
          mismatches++;
        end
        if (out_ch.burst_last !== head_beat.last) begin
          $display("%0t: burst_last expected %0b got %0b", $time, head_beat.last,
                   out_ch.burst_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d beats owed", $time, run_beats_owed.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, calm stretches, and the long hold-off on request
  initial begin
    int stall;
    int beats_seen;
    beats_seen = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      beats_seen++;
      if (beats_seen % 24 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 18);
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_item(input op_t op, input key_t key, input logic known,
                           input logic nbeats, input key_t exp_value, input logic exp_marker);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.new_value <= key;
    row_known       <= known;
    row_nbeats      <= nbeats;
    row_value       <= exp_value;
    row_marker      <= exp_marker;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and let the block go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (run_beats_owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the capacity register, then read it back
  task automatic cfg_set(input logic [CFG_DW-1:0] word);
    logic [CFG_DW-1:0] seen;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * int'(REG_HEAP_CAPACITY));
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cap_reg = word[CAP_W-1:0];
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    seen = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (seen !== {{(CFG_DW - CAP_W){1'b0}}, cap_reg}) begin
      $display("%0t: heap_capacity read expected %0d got %0d", $time, cap_reg, seen);
      mismatches++;
    end
  endtask

  initial begin
    int idx;
    int phase;
    int k;
    int r;
    key_t val;
    key_t last_key;
    op_t op;
    logic [CFG_DW-1:0] word;
    logic [CAP_W-1:0] phase_caps [PHASES];

    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_PUSH;
    in_ch.new_value = '0;
    out_ch.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    row_known       = 1'b0;
    row_nbeats      = 1'b0;
    row_value       = '0;
    row_marker      = 1'b0;
    heap_fill       = 0;
    cap_reg         = CAP_RESET;
    cycles          = 0;
    mismatches      = 0;
    hold_len        = 0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    last_key        = '0;
    phase_caps      = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd2, 6'd0, 6'd5, 6'd32};

    // kind, op, value, known, nbeats, exp_value, exp_marker
    plan = '{
      // flush straight after reset: marker only
      '{ROW_ITEM, OP_FLUSH, 32'sd0,   1'b1, 1'b1, 32'sd0, 1'b1},
      '{ROW_ITEM, OP_PUSH,  KEY_MAX,  1'b1, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  KEY_MIN,  1'b1, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  32'sd0,   1'b1, 1'b0, 32'sd0, 1'b0},
      // value on a flush is don't-care
      '{ROW_ITEM, OP_FLUSH, -32'sd1,  1'b0, 1'b0, 32'sd0, 1'b0},
      // capacity 0 behaves as 1
      '{ROW_CFG,  OP_PUSH,  32'sd0,   1'b0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  32'sd5,   1'b1, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  32'sd9,   1'b1, 1'b1, 32'sd5, 1'b0},
      // equal to the top is not a replacement
      '{ROW_ITEM, OP_PUSH,  32'sd9,   1'b0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  32'sd8,   1'b0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  -32'sd1,  1'b0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_FLUSH, KEY_MAX,  1'b0, 1'b0, 32'sd0, 1'b0},
      // above the depth: clamps to the depth
      '{ROW_CFG,  OP_PUSH,  32'sd63,  1'b0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_FLUSH, KEY_MIN,  1'b1, 1'b1, 32'sd0, 1'b1},
      '{ROW_CFG,  OP_PUSH,  32'sd3,   1'b0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  32'sd4,   1'b1, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  32'sd4,   1'b1, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  32'sd4,   1'b1, 1'b0, 32'sd0, 1'b0},
      // sift-down between equal children
      '{ROW_ITEM, OP_PUSH,  32'sd7,   1'b1, 1'b1, 32'sd4, 1'b0},
      // capacity dropped under the fill: replace, never insert
      '{ROW_CFG,  OP_PUSH,  32'sd1,   1'b0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_PUSH,  32'sd100, 1'b1, 1'b1, 32'sd4, 1'b0},
      '{ROW_ITEM, OP_PUSH,  -32'sd5,  1'b0, 1'b0, 32'sd0, 1'b0},
      '{ROW_ITEM, OP_FLUSH, 32'sd0,   1'b0, 1'b0, 32'sd0, 1'b0},
      '{ROW_CFG,  OP_PUSH,  32'sd32,  1'b0, 1'b0, 32'sd0, 1'b0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < PLAN_ROWS; idx++) begin
      if (plan[idx].kind == ROW_CFG) begin
        settle();
        cfg_set(CFG_DW'(plan[idx].value));
      end else begin
        send_item(plan[idx].op, plan[idx].value, plan[idx].known, plan[idx].nbeats,
                  plan[idx].exp_value, plan[idx].exp_marker);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      word = $urandom();
      word[CAP_W-1:0] = (phase == 5) ? CAP_W'($urandom_range(0, 63)) : phase_caps[phase];
      cfg_set(word);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 16 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        // capacity 1 phase: every push onto a filled heap yields a beat, so the hold backs up the input
        if (phase == 2 && k == 10) hold_len = HOLD_CYCLES;
        if (phase == 5 && k == 30) settle();
        r = $urandom_range(0, 99);
        op = OP_PUSH;
        if (r < 4) begin
          op = OP_FLUSH;
          val = $urandom();
        end else if (r < 60) begin
          // mostly rising keys so the heap fills and replaces
          val = last_key + $urandom_range(0, 48) - 8;
        end else if (r < 80) begin
          val = $urandom();
        end else if (r < 92) begin
          val = $urandom_range(0, 40) - 20;
        end else begin
          case ($urandom_range(0, 3))
            0: val = KEY_MAX;
            1: val = KEY_MIN;
            2: val = 32'sd0;
            default: val = -32'sd1;
          endcase
        end
        if (op == OP_PUSH) last_key = val;
        send_item(op, val, 1'b0, 1'b0, 32'sd0, 1'b0);
      end
    end

    in_ch.valid <= 1'b0;
    for (k = 0; k < 50000 && run_beats_owed.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (run_beats_owed.size() != 0) begin
      $display("%0t: %0d beats never arrived", $time, run_beats_owed.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
